// File: sv/grpe_pkg.sv
// shared types and constants for the grid ray paint engine
`default_nettype none

package grpe_pkg;

  localparam int unsigned CoordW = 7;
  localparam int unsigned ColorW = 8;

  localparam logic [ColorW-1:0] BlankCell = 8'd46;

  localparam logic       OpPaint = 1'b0;
  localparam logic       OpRead  = 1'b1;

  localparam logic [1:0] DirRight = 2'd0;
  localparam logic [1:0] DirUp    = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirDown  = 2'd3;

  localparam logic [1:0] RegRowCount = 2'd0;
  localparam logic [1:0] RegColCount = 2'd1;

  typedef enum logic [1:0] {
    CmdPaint  = 2'd0,
    CmdRead   = 2'd1,
    CmdReject = 2'd2
  } cmd_kind_e;

  // a span walks idx from first to last; fixed is the row (horizontal) or column (vertical)
  typedef struct packed {
    cmd_kind_e          kind;
    logic               vertical;
    logic [CoordW-1:0]  fixed;
    logic [CoordW-1:0]  first;
    logic [CoordW-1:0]  last;
    logic [ColorW-1:0]  color;
  } cmd_t;

  typedef struct packed {
    logic [ColorW-1:0] cell_color;
    logic              status;
  } res_t;

endpackage

`default_nettype wire

// File: sv/grpe_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module grpe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/grpe_fifo.sv
// small register queue used between front and back and on the result side
`default_nettype none

module grpe_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/grpe_front.sv
// front end: grid size registers and classification of incoming items into commands
`default_nettype none

module grpe_front #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [6:0]           cfg_data_i,
  input  wire logic                 operation_i,
  input  wire logic [6:0]           target_row_i,
  input  wire logic [6:0]           target_col_i,
  input  wire logic [7:0]           paint_color_i,
  input  wire logic [1:0]           direction_i,
  output grpe_pkg::cmd_t            cmd_o
);

  import grpe_pkg::*;

  localparam logic [CoordW-1:0] RowCap = (MAX_ROWS > 127) ? 7'd127 : CoordW'(MAX_ROWS);
  localparam logic [CoordW-1:0] ColCap = (MAX_COLS > 127) ? 7'd127 : CoordW'(MAX_COLS);

  logic [CoordW-1:0] row_count_q, col_count_q;
  logic [CoordW-1:0] nr, nc, r, c;
  logic              outside;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= 7'd64;
      col_count_q <= 7'd64;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegRowCount) begin
        row_count_q <= cfg_data_i;
      end
      if (cfg_index_i == RegColCount) begin
        col_count_q <= cfg_data_i;
      end
    end
  end

  assign nr = (row_count_q < RowCap) ? row_count_q : RowCap;
  assign nc = (col_count_q < ColCap) ? col_count_q : ColCap;
  assign r  = target_row_i - 1'b1;
  assign c  = target_col_i - 1'b1;

  assign outside = (target_row_i == '0) || (target_row_i > nr) ||
                   (target_col_i == '0) || (target_col_i > nc);

  always_comb begin
    cmd_o          = '0;
    cmd_o.color    = paint_color_i;
    cmd_o.fixed    = r;
    cmd_o.first    = c;
    cmd_o.last     = c;
    if (outside) begin
      cmd_o.kind = CmdReject;
    end else if (operation_i == OpRead) begin
      cmd_o.kind = CmdRead;
    end else begin
      cmd_o.kind = CmdPaint;
      case (direction_i)
        DirRight: begin
          cmd_o.first = c;
          cmd_o.last  = nc - 1'b1;
        end
        DirUp: begin
          cmd_o.vertical = 1'b1;
          cmd_o.fixed    = c;
          cmd_o.first    = '0;
          cmd_o.last     = r;
        end
        DirLeft: begin
          cmd_o.first = '0;
          cmd_o.last  = c;
        end
        DirDown: begin
          cmd_o.vertical = 1'b1;
          cmd_o.fixed    = c;
          cmd_o.first    = r;
          cmd_o.last     = nr - 1'b1;
        end
        default: begin
          cmd_o.first = c;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/grpe_back.sv
// back end: clearing pass, span writes and cell reads against the cell memory
`default_nettype none

module grpe_back #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  grpe_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output grpe_pkg::res_t      res_o,
  output logic                clearing_o
);

  import grpe_pkg::*;

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StPaint = 2'd2;
  localparam logic [1:0] StRead  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [CoordW-1:0] cur_q, cur_d, last_q, last_d, fixed_q, fixed_d;
  logic              vert_q, vert_d;
  logic [ColorW-1:0] color_q, color_d;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [ColorW-1:0] ram_wdata, ram_rdata;

  function automatic logic [AddrW-1:0] cell_addr(input logic vertical,
                                                 input logic [CoordW-1:0] fixed,
                                                 input logic [CoordW-1:0] idx);
    logic [AddrW-1:0] row, col;
    row = AddrW'(vertical ? idx : fixed);
    col = AddrW'(vertical ? fixed : idx);
    return row * AddrW'(MAX_COLS) + col;
  endfunction

  assign clearing_o = (state_q == StClear);
  assign ram_we     = (state_q == StClear) || (state_q == StPaint);
  assign ram_wdata  = (state_q == StClear) ? BlankCell : color_q;
  assign ram_waddr  = (state_q == StClear) ? clr_q : cell_addr(vert_q, fixed_q, cur_q);
  assign ram_raddr  = cell_addr(cmd_i.vertical, cmd_i.fixed, cmd_i.first);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cur_d      = cur_q;
    last_d     = last_q;
    fixed_d    = fixed_q;
    vert_d     = vert_q;
    color_d    = color_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        // the result queue slot stays free while this command is in flight
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CmdReject: begin
              res_push_o   = 1'b1;
              res_o.status = 1'b1;
            end
            CmdRead: begin
              state_d = StRead;
            end
            default: begin
              cur_d   = cmd_i.first;
              last_d  = cmd_i.last;
              fixed_d = cmd_i.fixed;
              vert_d  = cmd_i.vertical;
              color_d = cmd_i.color;
              state_d = StPaint;
            end
          endcase
        end
      end
      StPaint: begin
        cur_d = cur_q + 1'b1;
        if (cur_q == last_q) begin
          res_push_o = 1'b1;
          state_d    = StIdle;
        end
      end
      StRead: begin
        res_push_o       = 1'b1;
        res_o.cell_color = ram_rdata;
        state_d          = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    last_q  <= last_d;
    fixed_q <= fixed_d;
    vert_q  <= vert_d;
    color_q <= color_d;
  end

  grpe_ram #(
    .Width (ColorW),
    .Depth (Depth)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// File: sv/grid_ray_paint_engine.sv
// top level: front classifier, command queue, back end and result queue
// the back end takes a new command only once the last is done: an out-of-grid item pushes
// its result as it is taken, a read pushes the registered memory read, a paint writes its span
// one memory write a cycle and then pushes its result; the single write port sets this rate
// after reset the back end clears all MAX_ROWS*MAX_COLS cells to '.', one a cycle,
// and full is held high until it is done
`default_nettype none

module grid_ray_paint_engine #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [6:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic       operation_i,
  input  wire logic [6:0] target_row_i,
  input  wire logic [6:0] target_col_i,
  input  wire logic [7:0] paint_color_i,
  input  wire logic [1:0] direction_i,
  output logic            empty,
  input  wire logic       pop,
  output logic      [7:0] cell_color_o,
  output logic            status_o
);

  import grpe_pkg::*;

  cmd_t cmd_in, cmd_head;
  res_t res_in, res_head;
  logic cmd_full, cmd_empty, cmd_pop;
  logic res_full, res_push, clearing;

  assign full         = cmd_full | clearing;
  assign cell_color_o = res_head.cell_color;
  assign status_o     = res_head.status;

  grpe_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .operation_i   (operation_i),
    .target_row_i  (target_row_i),
    .target_col_i  (target_col_i),
    .paint_color_i (paint_color_i),
    .direction_i   (direction_i),
    .cmd_o         (cmd_in)
  );

  grpe_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push & ~clearing),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  grpe_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (~cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  grpe_fifo #(
    .Width ($bits(res_t)),
    .Depth (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

// File: tb/tb_grid_ray_paint_engine.sv
// self-checking testbench for the grid ray paint engine: directed and random ray paints and reads
module tb_grid_ray_paint_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import grpe_pkg::*;

  localparam int unsigned GridRows  = 64;
  localparam int unsigned GridCols  = 64;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned PhaseBeats = 375;
  localparam int unsigned ResizeEvery = 125;

  typedef struct packed {
    logic              op;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [ColorW-1:0] color;
    logic [1:0]        dir;
  } ray_item_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [1:0]        cfg_index_i   = RegRowCount;
  logic [6:0]        cfg_data_i    = '0;
  logic              push          = 1'b0;
  logic              full;
  logic              operation_i   = OpPaint;
  logic [6:0]        target_row_i  = '0;
  logic [6:0]        target_col_i  = '0;
  logic [7:0]        paint_color_i = '0;
  logic [1:0]        direction_i   = DirRight;
  logic              empty;
  logic              pop           = 1'b0;
  logic [7:0]        cell_color_o;
  logic              status_o;

  // mirror of the cell store and the grid size registers
  logic [ColorW-1:0] grid_mirror [GridRows][GridCols];
  int unsigned       row_limit;
  int unsigned       col_limit;
  res_t              cell_reply_q [$];
  res_t              head_reply;

  int unsigned       send_idle_pct = 0;
  int unsigned       pop_stall_pct = 0;
  int unsigned       fault_count   = 0;
  int unsigned       quiet_cycles  = 0;

  grid_ray_paint_engine #(
    .MAX_ROWS(GridRows),
    .MAX_COLS(GridCols)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .operation_i  (operation_i),
    .target_row_i (target_row_i),
    .target_col_i (target_col_i),
    .paint_color_i(paint_color_i),
    .direction_i  (direction_i),
    .empty        (empty),
    .pop          (pop),
    .cell_color_o (cell_color_o),
    .status_o     (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  function automatic int unsigned rows_live();
    return (row_limit < GridRows) ? row_limit : GridRows;
  endfunction

  function automatic int unsigned cols_live();
    return (col_limit < GridCols) ? col_limit : GridCols;
  endfunction

  function automatic ray_item_t make_ray(logic op, int unsigned row, int unsigned col,
                                         logic [7:0] color, logic [1:0] dir);
    ray_item_t it;
    it.op    = op;
    it.row   = row[6:0];
    it.col   = col[6:0];
    it.color = color;
    it.dir   = dir;
    return it;
  endfunction

  // applies one accepted item to the mirror and works out its reply
  task automatic apply_ray_item(input ray_item_t it, output res_t reply);
    int unsigned nr;
    int unsigned nc;
    int unsigned rr;
    int unsigned cc;
    nr = rows_live();
    nc = cols_live();
    reply.cell_color = '0;
    reply.status     = 1'b0;
    if (it.row == 0 || it.row > nr || it.col == 0 || it.col > nc) begin
      reply.status = 1'b1;
    end else begin
      rr = it.row - 1;
      cc = it.col - 1;
      if (it.op == OpRead) begin
        reply.cell_color = grid_mirror[rr][cc];
      end else begin
        case (it.dir)
          DirRight: for (int unsigned i = cc; i < nc; i++) grid_mirror[rr][i] = it.color;
          DirUp:    for (int unsigned i = 0; i <= rr; i++) grid_mirror[i][cc] = it.color;
          DirLeft:  for (int unsigned i = 0; i <= cc; i++) grid_mirror[rr][i] = it.color;
          default:  for (int unsigned i = rr; i < nr; i++) grid_mirror[i][cc] = it.color;
        endcase
      end
    end
  endtask

  // called at a falling edge; returns at the falling edge after the beat with push still high
  task automatic send_ray_item(input ray_item_t it);
    res_t reply;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push          <= 1'b1;
    operation_i   <= it.op;
    target_row_i  <= it.row;
    target_col_i  <= it.col;
    paint_color_i <= it.color;
    direction_i   <= it.dir;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    apply_ray_item(it, reply);
    cell_reply_q.push_back(reply);
    @(negedge clk_i);
  endtask

  // hold off the sender until every reply has come back
  task automatic settle_grid();
    push <= 1'b0;
    @(negedge clk_i);
    while (cell_reply_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_grid_size(input logic [1:0] idx, input int unsigned val);
    settle_grid();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[6:0];
    if (idx == RegRowCount) row_limit = val & 32'h7f;
    else                    col_limit = val & 32'h7f;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int unsigned random_grid_size();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0)      return 127;
    else if (pick == 1) return 64;
    else if (pick < 5)  return $urandom_range(8, 1);
    else                return $urandom_range(64, 1);
  endfunction

  // mostly in-grid paints and reads, some out-of-grid coordinates
  function automatic ray_item_t random_ray_item();
    ray_item_t   it;
    int unsigned nr;
    int unsigned nc;
    nr = rows_live();
    nc = cols_live();
    it.op    = ($urandom_range(99) < 55) ? OpPaint : OpRead;
    it.color = ColorW'($urandom_range(255));
    it.dir   = 2'($urandom_range(3));
    if (nr == 0 || nc == 0 || $urandom_range(99) < 10) begin
      it.row = CoordW'($urandom_range(127));
      it.col = CoordW'($urandom_range(127));
    end else begin
      it.row = CoordW'($urandom_range(nr, 1));
      it.col = CoordW'($urandom_range(nc, 1));
    end
    return it;
  endfunction

  task automatic test_blank_grid();
    // reads ignore color and direction
    send_ray_item(make_ray(OpRead, 1, 1, 8'hff, DirDown));
    send_ray_item(make_ray(OpRead, 64, 64, 8'h00, DirRight));
    send_ray_item(make_ray(OpRead, 1, 64, 8'h5a, DirUp));
    send_ray_item(make_ray(OpRead, 64, 1, 8'ha5, DirLeft));
  endtask

  task automatic test_ray_directions();
    send_ray_item(make_ray(OpPaint, 1, 1, 8'h00, DirRight));
    send_ray_item(make_ray(OpRead, 1, 64, 8'h00, DirRight));
    send_ray_item(make_ray(OpPaint, 64, 64, 8'hff, DirUp));
    send_ray_item(make_ray(OpRead, 1, 64, 8'h00, DirRight));
    send_ray_item(make_ray(OpPaint, 64, 64, 8'h55, DirLeft));
    send_ray_item(make_ray(OpPaint, 1, 1, 8'haa, DirDown));
    send_ray_item(make_ray(OpRead, 64, 1, 8'h00, DirRight));
    send_ray_item(make_ray(OpRead, 64, 63, 8'h00, DirRight));
  endtask

  task automatic test_out_of_grid();
    send_ray_item(make_ray(OpRead, 0, 1, 8'h12, DirRight));
    send_ray_item(make_ray(OpPaint, 1, 0, 8'h34, DirDown));
    send_ray_item(make_ray(OpRead, 65, 1, 8'h56, DirUp));
    send_ray_item(make_ray(OpPaint, 1, 127, 8'h78, DirLeft));
    send_ray_item(make_ray(OpPaint, 127, 127, 8'h9a, DirRight));
  endtask

  task automatic test_grid_size_extremes();
    write_grid_size(RegRowCount, 1);
    write_grid_size(RegColCount, 1);
    send_ray_item(make_ray(OpPaint, 1, 1, 8'h3c, DirDown));
    send_ray_item(make_ray(OpRead, 1, 1, 8'h00, DirRight));
    send_ray_item(make_ray(OpRead, 2, 1, 8'h00, DirRight));
    // zero rows in use rejects everything
    write_grid_size(RegRowCount, 0);
    send_ray_item(make_ray(OpRead, 1, 1, 8'h00, DirRight));
    // counts above the store clamp to its size
    write_grid_size(RegRowCount, 127);
    write_grid_size(RegColCount, 127);
    send_ray_item(make_ray(OpPaint, 64, 64, 8'hc3, DirLeft));
    send_ray_item(make_ray(OpRead, 64, 64, 8'h00, DirRight));
    send_ray_item(make_ray(OpRead, 65, 64, 8'h00, DirRight));
    write_grid_size(RegRowCount, 64);
    write_grid_size(RegColCount, 64);
  endtask

  task automatic test_random_rays();
    int unsigned idle_tab  [4] = '{0, 48, 0, 16};
    int unsigned stall_tab [4] = '{0, 0, 48, 16};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      pop_stall_pct = stall_tab[p];
      for (int unsigned n = 0; n < PhaseBeats; n++) begin
        if (n % ResizeEvery == 0) begin
          write_grid_size(RegRowCount, random_grid_size());
          write_grid_size(RegColCount, random_grid_size());
        end else if ($urandom_range(99) == 0) begin
          settle_grid();
        end
        send_ray_item(random_ray_item());
      end
    end
    send_idle_pct = 0;
    pop_stall_pct = 0;
  endtask

  // reply checker
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (cell_reply_q.size() == 0) begin
        $error("unexpected reply: cell_color=%0h status=%0b", cell_color_o, status_o);
        fault_count++;
      end else begin
        head_reply = cell_reply_q.pop_front();
        if (cell_color_o !== head_reply.cell_color) begin
          $error("cell_color: expected %0h, got %0h", head_reply.cell_color, cell_color_o);
          fault_count++;
        end
        if (status_o !== head_reply.status) begin
          $error("status: expected %0b, got %0b", head_reply.status, status_o);
          fault_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat; covers the clearing pass after reset
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    for (int r = 0; r < GridRows; r++) begin
      for (int c = 0; c < GridCols; c++) grid_mirror[r][c] = BlankCell;
    end
    row_limit = 64;
    col_limit = 64;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_blank_grid();
    test_ray_directions();
    test_out_of_grid();
    test_grid_size_extremes();
    test_random_rays();

    settle_grid();
    repeat (80) @(posedge clk_i);
    if (cell_reply_q.size() != 0) begin
      $error("replies never came: %0d left", cell_reply_q.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/grpe_pkg.sv
sv/grpe_ram.sv
sv/grpe_fifo.sv
sv/grpe_front.sv
sv/grpe_back.sv
sv/grid_ray_paint_engine.sv
tb/tb_grid_ray_paint_engine.sv
